[rtl/core/pcse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pcse_pkg;

  // default sizing
  localparam int PLANE_COUNT_DEF = 3;
  localparam int SPACE_MAX_DEF   = 4096;

  // request kinds
  localparam logic [1:0] REQ_CFG_RD = 2'd0;
  localparam logic [1:0] REQ_CFG_WR = 2'd1;
  localparam logic [1:0] REQ_RAW_RD = 2'd2;
  localparam logic [1:0] REQ_RAW_WR = 2'd3;

  // byte planes
  localparam logic [1:0] PLANE_VALUE  = 2'd0;
  localparam logic [1:0] PLANE_RDONLY = 2'd1;
  localparam logic [1:0] PLANE_W1C    = 2'd2;

  // completion status
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_PARAM_ERR = 2'd1;
  localparam logic [1:0] STAT_RAW_REJ   = 2'd2;

  // register file
  localparam int          CFG_IDX_W  = 1;
  localparam int          CFG_DATA_W = 16;
  localparam logic [0:0]  CFG_DEVICE = 1'b0;
  localparam logic [0:0]  CFG_SPACE  = 1'b1;
  localparam logic [12:0] SPACE_RST  = 13'd256;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic finish;
    logic clear;
  } pcse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } pcse_sts_t;

endpackage

`default_nettype wire

[rtl/core/pcse_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcse_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output pcse_pkg::pcse_cmd_t cmd,
  input  pcse_pkg::pcse_sts_t sts
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RESP  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // commands to the datapath
  always_comb begin
    cmd.clear  = (state_r == S_CLEAR);
    cmd.accept = (state_r == S_IDLE) && in_tvalid;
    cmd.finish = (state_r == S_RESP) && (!out_valid_r || out_tready);
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (cmd.finish) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // result beat held until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pcse_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcse_datapath #(
  parameter int PLANE_COUNT     = pcse_pkg::PLANE_COUNT_DEF,
  parameter int SPACE_MAX_BYTES = pcse_pkg::SPACE_MAX_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  pcse_pkg::pcse_cmd_t               cmd,
  output pcse_pkg::pcse_sts_t               sts,
  input  wire                               cfg_wr_en,
  input  wire  [pcse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [pcse_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire  [63:0]                       in_tdata,
  input  wire  [3:0]                        in_tuser,
  output logic [31:0]                       out_tdata,
  output logic [1:0]                        out_tuser
);

  localparam int          WORDS     = SPACE_MAX_BYTES / 4;
  localparam int          AW        = $clog2(WORDS);
  localparam logic [12:0] SIZE_MAX  = 13'(SPACE_MAX_BYTES);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  // beat fields
  logic [1:0]  req_in, plane_in;
  logic [15:0] tgt_in;
  logic [11:0] off_in;
  logic [2:0]  n_in;
  logic [31:0] data_in;

  assign req_in   = in_tuser[1:0];
  assign plane_in = in_tuser[3:2];
  assign tgt_in   = in_tdata[15:0];
  assign off_in   = in_tdata[27:16];
  assign n_in     = in_tdata[30:28];
  assign data_in  = in_tdata[62:31];

  // register file
  logic [15:0] dev_r;
  logic [12:0] space_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r   <= '0;
      space_r <= pcse_pkg::SPACE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pcse_pkg::CFG_DEVICE: dev_r   <= cfg_wdata[15:0];
        pcse_pkg::CFG_SPACE:  space_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // access checks on the incoming beat
  logic [12:0]   size_use, end_in;
  logic          size_ok, cfg_ok, raw_ok, ok_in;
  logic [AW-1:0] word_in, word_nx;
  logic [AW-1:0] lane_addr_in [4];
  logic [3:0]    lane_en_in, bmask_in;
  logic [63:0]   rot_in;
  logic [1:0]    diff;

  always_comb begin
    size_use = (space_r > SIZE_MAX) ? SIZE_MAX : space_r;
    end_in   = {1'b0, off_in} + {10'b0, n_in};
    size_ok  = (n_in == 3'd1) ||
               ((n_in == 3'd2) && !off_in[0]) ||
               ((n_in == 3'd4) && (off_in[1:0] == 2'b00));
    cfg_ok   = (tgt_in == dev_r) && size_ok && (end_in < size_use);
    raw_ok   = (int'(plane_in) < PLANE_COUNT) && (n_in <= 3'd4) && (end_in <= size_use);
    ok_in    = ((req_in == pcse_pkg::REQ_CFG_RD) || (req_in == pcse_pkg::REQ_CFG_WR)) ?
               cfg_ok : raw_ok;
    word_in  = off_in[AW+1:2];
    word_nx  = word_in + AW'(1);
    for (int l = 0; l < 4; l++) begin
      diff            = 2'(l) - off_in[1:0];
      lane_addr_in[l] = (2'(l) >= off_in[1:0]) ? word_in : word_nx;
      lane_en_in[l]   = ({1'b0, diff} < n_in);
      bmask_in[l]     = (3'(l) < n_in);
    end
    // data byte 0 goes to the lane of the first byte
    rot_in = {data_in, data_in} << {off_in[1:0], 3'b000};
  end

  // request held for the response cycle
  logic [1:0]    req_r, plane_r, off0_r;
  logic          ok_r;
  logic [3:0]    lane_en_r, bmask_r;
  logic [31:0]   wlanes_r;
  logic [AW-1:0] lane_addr_r [4];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r     <= req_in;
      plane_r   <= plane_in;
      off0_r    <= off_in[1:0];
      ok_r      <= ok_in;
      lane_en_r <= lane_en_in;
      bmask_r   <= bmask_in;
      wlanes_r  <= rot_in[63:32];
      for (int l = 0; l < 4; l++) lane_addr_r[l] <= lane_addr_in[l];
    end
  end

  // clearing sweep after reset
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clear) clr_cnt_r <= clr_cnt_r + AW'(1);
  end

  assign sts.clear_last = (clr_cnt_r == LAST_WORD);

  // write merge for config writes
  logic [PLANE_COUNT-1:0][3:0][7:0] rword;
  logic [31:0] old_w, ro_w, wc_w, merged;

  always_comb begin
    old_w  = rword[pcse_pkg::PLANE_VALUE];
    ro_w   = rword[pcse_pkg::PLANE_RDONLY];
    wc_w   = rword[pcse_pkg::PLANE_W1C];
    merged = (old_w & ro_w) | (old_w & ~wlanes_r & wc_w & ~ro_w) |
             (wlanes_r & ~wc_w & ~ro_w);
  end

  // byte banks: one per plane and lane
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [7:0]    mem_r [WORDS];
      logic [7:0]    q_r;
      logic          we;
      logic [AW-1:0] waddr;
      logic [7:0]    wbyte;

      always_comb begin
        we = cmd.clear ||
             (cmd.finish && ok_r && lane_en_r[l] &&
              (((req_r == pcse_pkg::REQ_CFG_WR) && (p == pcse_pkg::PLANE_VALUE)) ||
               ((req_r == pcse_pkg::REQ_RAW_WR) && (plane_r == 2'(p)))));
        waddr = cmd.clear ? clr_cnt_r : lane_addr_r[l];
        if (cmd.clear) wbyte = 8'h00;
        else if (req_r == pcse_pkg::REQ_CFG_WR) wbyte = merged[8*l +: 8];
        else wbyte = wlanes_r[8*l +: 8];
      end

      always_ff @(posedge clk) begin
        if (we) mem_r[waddr] <= wbyte;
        if (cmd.accept) q_r <= mem_r[lane_addr_in[l]];
      end

      assign rword[p][l] = q_r;
    end
  end

  // read gather and status
  logic [31:0] sel_w, cfg_g, raw_g, mask_w, rd_nxt;
  logic [63:0] cfg_sh, raw_sh;
  logic [1:0]  st_nxt;

  always_comb begin
    sel_w = '0;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      if (plane_r == 2'(p)) sel_w = rword[p];
    end
    for (int l = 0; l < 4; l++) mask_w[8*l +: 8] = {8{bmask_r[l]}};
    cfg_sh = {old_w, old_w} >> {off0_r, 3'b000};
    raw_sh = {sel_w, sel_w} >> {off0_r, 3'b000};
    cfg_g  = cfg_sh[31:0] & mask_w;
    raw_g  = raw_sh[31:0] & mask_w;
    rd_nxt = '0;
    st_nxt = pcse_pkg::STAT_OK;
    case (req_r)
      pcse_pkg::REQ_CFG_RD: begin
        if (ok_r) rd_nxt = cfg_g;
        else begin
          rd_nxt = pcse_pkg::ALL_ONES;
          st_nxt = pcse_pkg::STAT_PARAM_ERR;
        end
      end
      pcse_pkg::REQ_CFG_WR: begin
        if (!ok_r) st_nxt = pcse_pkg::STAT_PARAM_ERR;
      end
      pcse_pkg::REQ_RAW_RD: begin
        if (ok_r) rd_nxt = raw_g;
        else st_nxt = pcse_pkg::STAT_RAW_REJ;
      end
      default: begin
        if (!ok_r) st_nxt = pcse_pkg::STAT_RAW_REJ;
      end
    endcase
  end

  // result register
  logic [31:0] out_data_r;
  logic [1:0]  out_stat_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= rd_nxt;
      out_stat_r <= st_nxt;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_stat_r;

endmodule

`default_nettype wire

[rtl/core/pci_config_space_emulator_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  tdata                                   tuser
// in_      slave      [15:0] target_number [27:16] byte_offset [1:0] req_type [3:2] plane_select
//                     [30:28] access_bytes [62:31] write_data
// out_     master     [31:0] read_data                        [1:0] status
// cfg_     write      cfg_index 0 device_number, 1 space_bytes (cfg_wdata low bits)
//
// each request is accepted with the bank read, then merged or gathered with
// the bank write-back; the byte banks have a single read port per lane
// after reset a clearing sweep of SPACE_MAX_BYTES/4 words (1024 by default) zeroes
// all planes; no request is taken during it, register writes are still taken
// a result not yet taken holds the next request in its response state

module pci_config_space_emulator_core #(
  parameter int PLANE_COUNT     = pcse_pkg::PLANE_COUNT_DEF,
  parameter int SPACE_MAX_BYTES = pcse_pkg::SPACE_MAX_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr_en,
  input  wire  [pcse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [pcse_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // [15:0] target_number, [27:16] byte_offset, [30:28] access_bytes,
  // [62:31] write_data, [63] zero
  input  wire  [63:0]                      in_tdata,
  // [1:0] req_type, [3:2] plane_select
  input  wire  [3:0]                       in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [31:0] read_data
  output logic [31:0]                      out_tdata,
  // [1:0] status
  output logic [1:0]                       out_tuser
);

  pcse_pkg::pcse_cmd_t cmd;
  pcse_pkg::pcse_sts_t sts;

  pcse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  pcse_datapath #(
    .PLANE_COUNT     (PLANE_COUNT),
    .SPACE_MAX_BYTES (SPACE_MAX_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

[sim/tb_pci_config_space_emulator_core.sv]
`timescale 1ns / 1ps

module tb_pci_config_space_emulator_core;
  import pcse_pkg::*;

  localparam int PHASE_ITEMS = 240;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;

  // one config or raw request as it travels on the input channel
  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] tgt;
    logic [1:0]  plane;
    logic [11:0] off;
    logic [2:0]  n;
    logic [31:0] wdata;
  } cfg_req_t;

  // one completion beat
  typedef struct packed {
    logic [31:0] rdata;
    logic [1:0]  status;
  } cfg_cpl_t;

  // directed row: request plus an optional hand-typed completion
  typedef struct packed {
    cfg_req_t    item;
    logic        known;
    cfg_cpl_t    cpl;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  // [15:0] target_number, [27:16] byte_offset, [30:28] access_bytes,
  // [62:31] write_data, [63] zero
  logic [63:0] in_tdata;
  // [1:0] req_type, [3:2] plane_select
  logic [3:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // [31:0] read_data
  logic [31:0] out_tdata;
  // [1:0] status
  logic [1:0]  out_tuser;

  pci_config_space_emulator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // shadow of the byte planes and registers
  bit [7:0]  plane_mem [0:PLANE_COUNT_DEF-1][0:SPACE_MAX_DEF-1];
  bit [15:0] dev_reg;
  bit [12:0] space_reg;

  cfg_cpl_t  pending_cpl[$];
  dir_row_t  dir_rows[$];
  int        mismatch_count;
  int        cycle_count;
  bit        pace_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run guard
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic int space_in_use();
    return (space_reg > SPACE_MAX_DEF) ? SPACE_MAX_DEF : int'(space_reg);
  endfunction

  // config access legality: number, size, alignment, end strictly below size
  function automatic bit cfg_access_ok(input cfg_req_t r);
    int n;
    n = int'(r.n);
    if (r.tgt != dev_reg) return 1'b0;
    if (n != 1 && n != 2 && n != 4) return 1'b0;
    if ((int'(r.off) & (n - 1)) != 0) return 1'b0;
    return (int'(r.off) + n) < space_in_use();
  endfunction

  // completion for one request, updating the shadow planes
  function automatic cfg_cpl_t predict_completion(input cfg_req_t r);
    cfg_cpl_t c;
    int       pos;
    bit [7:0] old, ro, wc, d;
    c.rdata  = '0;
    c.status = STAT_OK;
    case (r.req)
      REQ_CFG_RD: begin
        if (cfg_access_ok(r)) begin
          for (int i = 0; i < int'(r.n); i++)
            c.rdata[i*8 +: 8] = plane_mem[PLANE_VALUE][int'(r.off) + i];
        end else begin
          c.rdata  = ALL_ONES;
          c.status = STAT_PARAM_ERR;
        end
      end
      REQ_CFG_WR: begin
        if (!cfg_access_ok(r)) begin
          c.status = STAT_PARAM_ERR;
        end else begin
          // read-only bits hold, w1c bits clear on one, the rest take data
          for (int i = 0; i < int'(r.n); i++) begin
            pos = int'(r.off) + i;
            old = plane_mem[PLANE_VALUE][pos];
            ro  = plane_mem[PLANE_RDONLY][pos];
            wc  = plane_mem[PLANE_W1C][pos];
            d   = r.wdata[i*8 +: 8];
            plane_mem[PLANE_VALUE][pos] = (old & ro) | (old & ~d & wc & ~ro) | (d & ~wc & ~ro);
          end
        end
      end
      default: begin
        if (int'(r.plane) >= PLANE_COUNT_DEF || r.n > 3'd4 ||
            int'(r.off) + int'(r.n) > space_in_use()) begin
          c.status = STAT_RAW_REJ;
        end else if (r.req == REQ_RAW_RD) begin
          for (int i = 0; i < int'(r.n); i++)
            c.rdata[i*8 +: 8] = plane_mem[int'(r.plane)][int'(r.off) + i];
        end else begin
          for (int i = 0; i < int'(r.n); i++)
            plane_mem[int'(r.plane)][int'(r.off) + i] = r.wdata[i*8 +: 8];
        end
      end
    endcase
    return c;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] req, input logic [15:0] tgt,
                                      input logic [1:0] plane, input logic [11:0] off,
                                      input logic [2:0] n, input logic [31:0] wdata,
                                      input logic known, input logic [31:0] rdata,
                                      input logic [1:0] status);
    dir_row_t row;
    row.item.req   = req;
    row.item.tgt   = tgt;
    row.item.plane = plane;
    row.item.off   = off;
    row.item.n     = n;
    row.item.wdata = wdata;
    row.known      = known;
    row.cpl.rdata  = rdata;
    row.cpl.status = status;
    return row;
  endfunction

  // random request, mostly well-formed around the current number and size
  function automatic cfg_req_t pick_request();
    cfg_req_t r;
    int       eff;
    int       sel;
    r.req   = 2'($urandom_range(0, 3));
    r.tgt   = ($urandom_range(0, 99) < 85) ? dev_reg : 16'($urandom);
    r.plane = ($urandom_range(0, 9) == 0) ? 2'(PLANE_COUNT_DEF) : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0, 1, 2: r.n = 3'd1;
      3, 4, 5: r.n = 3'd2;
      6, 7:    r.n = 3'd4;
      default: r.n = 3'($urandom_range(0, 7));
    endcase
    eff = space_in_use();
    sel = $urandom_range(0, 9);
    if (sel < 5)
      r.off = 12'($urandom_range(0, 31));
    else if (sel < 8)
      r.off = (eff > 8) ? 12'(eff - 8 + $urandom_range(0, 7)) : 12'($urandom_range(0, eff));
    else
      r.off = 12'($urandom);
    // natural alignment most of the time
    if ($urandom_range(0, 3) != 0) begin
      if (r.n == 3'd2) r.off[0] = 1'b0;
      if (r.n == 3'd4) r.off[1:0] = 2'b00;
    end
    case ($urandom_range(0, 19))
      0:       r.wdata = '0;
      1:       r.wdata = '1;
      default: r.wdata = $urandom;
    endcase
    return r;
  endfunction

  // present one request beat and hold it until taken
  task automatic send_request(input cfg_req_t r);
    int gap;
    gap = pace_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, r.wdata, r.n, r.off, r.tgt};
    in_tuser  <= {r.plane, r.req};
    do @(posedge clk); while (in_tready !== 1'b1);
    if ($urandom_range(0, 49) == 0) pace_on = ~pace_on;
  endtask

  task automatic drain();
    while (pending_cpl.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register writes, only while idle
  task automatic set_config(input logic [15:0] dev, input logic [15:0] space);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DEVICE;
    cfg_wdata <= dev;
    @(posedge clk);
    cfg_index <= CFG_SPACE;
    cfg_wdata <= space;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dev_reg   = dev;
    space_reg = space[12:0];
  endtask

  // result side: random stall per beat, then check against oldest expectation
  initial begin
    cfg_cpl_t want;
    int       stall;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = pace_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1 || out_tready !== 1'b1);
      if (pending_cpl.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, '0);
      end else begin
        want = pending_cpl.pop_front();
        if (out_tdata !== want.rdata)
          report_mismatch("read_data", out_tdata, want.rdata);
        if (out_tuser !== want.status)
          report_mismatch("status", {30'd0, out_tuser}, {30'd0, want.status});
      end
    end
  end

  // main sequence
  initial begin
    cfg_cpl_t   got_cpl;
    logic [15:0] dev_list   [0:5];
    logic [15:0] space_list [0:5];
    mismatch_count = 0;
    pace_on        = 1'b1;
    dev_reg        = '0;
    space_reg      = SPACE_RST;
    for (int p = 0; p < PLANE_COUNT_DEF; p++)
      for (int a = 0; a < SPACE_MAX_DEF; a++)
        plane_mem[p][a] = '0;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, run at the reset register values
    dir_rows.push_back(mk_row(REQ_CFG_RD, 16'h0000, 2'd0, 12'd0, 3'd4, '0,
                              1'b1, 32'h0, STAT_OK));
    dir_rows.push_back(mk_row(REQ_CFG_RD, 16'hffff, 2'd0, 12'd0, 3'd4, '0,
                              1'b1, ALL_ONES, STAT_PARAM_ERR));
    dir_rows.push_back(mk_row(REQ_CFG_RD, 16'h0000, 2'd0, 12'd0, 3'd3, '0,
                              1'b1, ALL_ONES, STAT_PARAM_ERR));
    dir_rows.push_back(mk_row(REQ_CFG_RD, 16'h0000, 2'd0, 12'd0, 3'd0, '0,
                              1'b1, ALL_ONES, STAT_PARAM_ERR));
    dir_rows.push_back(mk_row(REQ_CFG_RD, 16'h0000, 2'd0, 12'd2, 3'd4, '0,
                              1'b1, ALL_ONES, STAT_PARAM_ERR));
    // end exactly at the size is refused for config accesses
    dir_rows.push_back(mk_row(REQ_CFG_RD, 16'h0000, 2'd0, 12'd252, 3'd4, '0,
                              1'b1, ALL_ONES, STAT_PARAM_ERR));
    dir_rows.push_back(mk_row(REQ_CFG_RD, 16'h0000, 2'd0, 12'd248, 3'd4, '0,
                              1'b1, 32'h0, STAT_OK));
    // load value, read-only and w1c planes with overlapping masks
    dir_rows.push_back(mk_row(REQ_RAW_WR, 16'h1234, PLANE_VALUE, 12'd0, 3'd4, 32'ha5a5_a5a5,
                              1'b1, 32'h0, STAT_OK));
    dir_rows.push_back(mk_row(REQ_RAW_WR, 16'h0000, PLANE_RDONLY, 12'd0, 3'd4, 32'hff00_ff00,
                              1'b1, 32'h0, STAT_OK));
    dir_rows.push_back(mk_row(REQ_RAW_WR, 16'h0000, PLANE_W1C, 12'd0, 3'd4, 32'h0ff0_0ff0,
                              1'b1, 32'h0, STAT_OK));
    dir_rows.push_back(mk_row(REQ_CFG_WR, 16'h0000, 2'd0, 12'd0, 3'd4, 32'hffff_ffff,
                              1'b0, '0, '0));
    dir_rows.push_back(mk_row(REQ_CFG_RD, 16'h0000, 2'd0, 12'd0, 3'd4, '0, 1'b0, '0, '0));
    dir_rows.push_back(mk_row(REQ_CFG_WR, 16'h0000, 2'd0, 12'd0, 3'd4, 32'h0000_0000,
                              1'b0, '0, '0));
    dir_rows.push_back(mk_row(REQ_CFG_RD, 16'h0000, 2'd0, 12'd0, 3'd4, '0, 1'b0, '0, '0));
    // raw rejections: bad plane, oversize, past the end
    dir_rows.push_back(mk_row(REQ_RAW_RD, 16'h0000, 2'(PLANE_COUNT_DEF), 12'd0, 3'd4, '0,
                              1'b1, 32'h0, STAT_RAW_REJ));
    dir_rows.push_back(mk_row(REQ_RAW_RD, 16'h0000, PLANE_VALUE, 12'd0, 3'd5, '0,
                              1'b1, 32'h0, STAT_RAW_REJ));
    dir_rows.push_back(mk_row(REQ_RAW_RD, 16'h0000, PLANE_VALUE, 12'd0, 3'd7, '0,
                              1'b1, 32'h0, STAT_RAW_REJ));
    dir_rows.push_back(mk_row(REQ_RAW_WR, 16'h0000, PLANE_VALUE, 12'd253, 3'd4, '1,
                              1'b1, 32'h0, STAT_RAW_REJ));
    dir_rows.push_back(mk_row(REQ_RAW_RD, 16'h0000, PLANE_VALUE, 12'd252, 3'd4, '0,
                              1'b0, '0, '0));
    // empty raw accesses, one sitting right at the size
    dir_rows.push_back(mk_row(REQ_RAW_WR, 16'h0000, PLANE_VALUE, 12'd256, 3'd0, '1,
                              1'b1, 32'h0, STAT_OK));
    dir_rows.push_back(mk_row(REQ_RAW_RD, 16'h0000, PLANE_W1C, 12'd4, 3'd0, '0,
                              1'b1, 32'h0, STAT_OK));
    // raw needs no alignment
    dir_rows.push_back(mk_row(REQ_RAW_RD, 16'hbeef, PLANE_RDONLY, 12'd1, 3'd3, '0,
                              1'b0, '0, '0));
    dir_rows.push_back(mk_row(REQ_CFG_WR, 16'h0001, 2'd0, 12'd0, 3'd4, 32'h1234_5678,
                              1'b1, 32'h0, STAT_PARAM_ERR));
    dir_rows.push_back(mk_row(REQ_CFG_WR, 16'h0000, 2'd0, 12'd2, 3'd2, 32'hffff_1234,
                              1'b0, '0, '0));
    dir_rows.push_back(mk_row(REQ_CFG_RD, 16'h0000, 2'd0, 12'd0, 3'd4, '0, 1'b0, '0, '0));

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].item);
      got_cpl = predict_completion(dir_rows[i].item);
      pending_cpl.push_back(dir_rows[i].known ? dir_rows[i].cpl : got_cpl);
    end
    in_tvalid <= 1'b0;
    drain();

    // register settings: masked oversize, minimum, maximum, tiny, zero, random
    dev_list[0] = 16'hffff;  space_list[0] = 16'hffff;
    dev_list[1] = 16'h0000;  space_list[1] = 16'd64;
    dev_list[2] = 16'h5a3c;  space_list[2] = 16'd4096;
    dev_list[3] = 16'ha5c3;  space_list[3] = 16'd5;
    dev_list[4] = 16'h0001;  space_list[4] = 16'd0;
    dev_list[5] = 16'($urandom);
    space_list[5] = 16'($urandom_range(64, 4096));

    for (int ph = 0; ph < 6; ph++) begin
      set_config(dev_list[ph], space_list[ph]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        cfg_req_t r;
        r = pick_request();
        send_request(r);
        pending_cpl.push_back(predict_completion(r));
      end
      in_tvalid <= 1'b0;
      drain();
    end

    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/core/pcse_pkg.sv
rtl/core/pcse_ctrl.sv
rtl/core/pcse_datapath.sv
rtl/core/pci_config_space_emulator_core.sv
sim/tb_pci_config_space_emulator_core.sv
